FILE: design/rotation_matrix_to_quaternion_macros.svh
// Assertion macros for the checker file of the rotation matrix to quaternion block.
`ifndef ROTATION_MATRIX_TO_QUATERNION_MACROS_SVH
`define ROTATION_MATRIX_TO_QUATERNION_MACROS_SVH

// A property that is checked only while the block is out of reset.
`define RMQ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// A property that is checked on every clock edge, reset included.
`define RMQ_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

FILE: design/rmq_pkg.sv
// Package with the shared types and constants of the rotation matrix to quaternion block.
`timescale 1ns / 1ps

package rmq_pkg;

    // Default number of fraction bits.
    localparam int FRAC_BITS_DEF = 16;
    // Width of every input and output field.
    localparam int FIELD_W = 18;
    // Largest positive field value.
    localparam int FIELD_MAX = 131071;
    // Width of a signed off-diagonal sum or difference.
    localparam int D_W = 19;
    // Quotient bits kept by the divider; enough to reach the clamp level.
    localparam int QUO_W = 19;

    // Which component comes from the square root.
    typedef enum logic [1:0] {
        SEL_TRACE,
        SEL_X,
        SEL_Y,
        SEL_Z
    } t_sel;

    // Information that travels beside the radicand through the root stages.
    // Lane 0 holds the dividend for the first divided component, lanes 1 and 2
    // the next two, in the order w/x/y/z with the root component skipped.
    typedef struct packed {
        t_sel                       sel;
        logic [2:0][D_W-1:0]        d;
    } t_side;

endpackage

FILE: design/rotation_matrix_to_quaternion.sv
// Top level of the rotation matrix to quaternion converter.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-------------------------------
//  matrix  | in        | i_valid / o_ready  | i_r00 .. i_r22, 18-bit signed
//  quat    | out       | o_valid / i_ready  | o_qx o_qy o_qz o_qw, 18-bit
//
// One matrix is taken per cycle while o_ready is high. A matrix passes the
// front register, the one-bit-per-stage square root, the one-bit-per-stage
// dividers and the output register. Reset clears the valid bits of all stages.
// While a result waits and i_ready is low, the whole pipeline holds and
// o_ready is low; bubbles are not squeezed out.
`timescale 1ns / 1ps

module rotation_matrix_to_quaternion #(
    parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic signed [rmq_pkg::FIELD_W-1:0] i_r00,
    input  logic signed [rmq_pkg::FIELD_W-1:0] i_r01,
    input  logic signed [rmq_pkg::FIELD_W-1:0] i_r02,
    input  logic signed [rmq_pkg::FIELD_W-1:0] i_r10,
    input  logic signed [rmq_pkg::FIELD_W-1:0] i_r11,
    input  logic signed [rmq_pkg::FIELD_W-1:0] i_r12,
    input  logic signed [rmq_pkg::FIELD_W-1:0] i_r20,
    input  logic signed [rmq_pkg::FIELD_W-1:0] i_r21,
    input  logic signed [rmq_pkg::FIELD_W-1:0] i_r22,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic signed [rmq_pkg::FIELD_W-1:0] o_qx,
    output logic signed [rmq_pkg::FIELD_W-1:0] o_qy,
    output logic signed [rmq_pkg::FIELD_W-1:0] o_qz,
    output logic signed [rmq_pkg::FIELD_W-1:0] o_qw
);

    localparam int FW      = rmq_pkg::FIELD_W;
    localparam int QW      = rmq_pkg::QUO_W;
    localparam int RAD_W   = ((FRAC_BITS > FW) ? FRAC_BITS : FW) + 3;
    localparam int ROOT_W  = (RAD_W + FRAC_BITS + 1) / 2;
    localparam int LIM     = (FRAC_BITS > FW - 2) ? rmq_pkg::FIELD_MAX : (1 << FRAC_BITS);

    logic                   en;
    logic                   f_valid, s_valid, d_valid;
    rmq_pkg::t_side         f_side, s_side;
    logic [RAD_W-1:0]       f_rad;
    logic [ROOT_W-1:0]      s_root, d_root;
    rmq_pkg::t_sel          d_sel;
    logic [2:0][QW-1:0]     d_quo;
    logic [2:0]             d_ovf, d_neg;

    logic signed [FW-1:0]   lane_q [3];
    logic signed [FW-1:0]   root_q;
    logic signed [FW-1:0]   n_qx, n_qy, n_qz, n_qw;
    logic signed [FW-1:0]   r_qx, r_qy, r_qz, r_qw;
    logic                   r_valid;

    // The pipeline moves when the output register is empty or being taken.
    assign en      = !r_valid || i_ready;
    assign o_ready = en;

    rmq_front #(
        .FRAC_BITS (FRAC_BITS),
        .RAD_W     (RAD_W)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_valid),
        .i_r00   (i_r00),
        .i_r01   (i_r01),
        .i_r02   (i_r02),
        .i_r10   (i_r10),
        .i_r11   (i_r11),
        .i_r12   (i_r12),
        .i_r20   (i_r20),
        .i_r21   (i_r21),
        .i_r22   (i_r22),
        .o_valid (f_valid),
        .o_side  (f_side),
        .o_rad   (f_rad)
    );

    rmq_sqrt #(
        .FRAC_BITS (FRAC_BITS),
        .RAD_W     (RAD_W),
        .ROOT_W    (ROOT_W)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (f_valid),
        .i_side  (f_side),
        .i_rad   (f_rad),
        .o_valid (s_valid),
        .o_side  (s_side),
        .o_root  (s_root)
    );

    rmq_div #(
        .FRAC_BITS (FRAC_BITS),
        .ROOT_W    (ROOT_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (s_valid),
        .i_side  (s_side),
        .i_root  (s_root),
        .o_valid (d_valid),
        .o_sel   (d_sel),
        .o_root  (d_root),
        .o_quo   (d_quo),
        .o_ovf   (d_ovf),
        .o_neg   (d_neg)
    );

    // Clamp the divided lanes and the root component, then apply signs.
    always_comb begin
        logic [ROOT_W-1:0] half;
        logic [FW-1:0]     mag;
        for (int l = 0; l < 3; l++) begin
            if (d_root == '0) begin
                mag = '0;
            end else if (d_ovf[l] || (32'(d_quo[l]) > 32'(LIM))) begin
                mag = FW'(LIM);
            end else begin
                mag = d_quo[l][FW-1:0];
            end
            lane_q[l] = d_neg[l] ? -$signed(mag) : $signed(mag);
        end
        half   = d_root >> 1;
        root_q = (32'(half) > 32'(LIM)) ? FW'(LIM) : FW'(half);
    end

    // Route lanes to components according to the chosen case.
    always_comb begin
        unique case (d_sel)
            rmq_pkg::SEL_TRACE: begin
                n_qx = lane_q[0];
                n_qy = lane_q[1];
                n_qz = lane_q[2];
                n_qw = root_q;
            end
            rmq_pkg::SEL_X: begin
                n_qx = root_q;
                n_qy = lane_q[1];
                n_qz = lane_q[2];
                n_qw = lane_q[0];
            end
            rmq_pkg::SEL_Y: begin
                n_qx = lane_q[1];
                n_qy = root_q;
                n_qz = lane_q[2];
                n_qw = lane_q[0];
            end
            default: begin
                n_qx = lane_q[1];
                n_qy = lane_q[2];
                n_qz = root_q;
                n_qw = lane_q[0];
            end
        endcase
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (en) begin
            r_valid <= d_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_qx <= n_qx;
            r_qy <= n_qy;
            r_qz <= n_qz;
            r_qw <= n_qw;
        end
    end

    assign o_valid = r_valid;
    assign o_qx    = r_qx;
    assign o_qy    = r_qy;
    assign o_qz    = r_qz;
    assign o_qw    = r_qw;

endmodule

FILE: design/rmq_front.sv
// Front stage: case selection, radicand and dividends of the quaternion conversion.
`timescale 1ns / 1ps

module rmq_front #(
    parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF,
    parameter int RAD_W     = 21
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_en,
    input  logic                               i_valid,
    input  logic signed [rmq_pkg::FIELD_W-1:0] i_r00,
    input  logic signed [rmq_pkg::FIELD_W-1:0] i_r01,
    input  logic signed [rmq_pkg::FIELD_W-1:0] i_r02,
    input  logic signed [rmq_pkg::FIELD_W-1:0] i_r10,
    input  logic signed [rmq_pkg::FIELD_W-1:0] i_r11,
    input  logic signed [rmq_pkg::FIELD_W-1:0] i_r12,
    input  logic signed [rmq_pkg::FIELD_W-1:0] i_r20,
    input  logic signed [rmq_pkg::FIELD_W-1:0] i_r21,
    input  logic signed [rmq_pkg::FIELD_W-1:0] i_r22,
    output logic                               o_valid,
    output rmq_pkg::t_side                     o_side,
    output logic [RAD_W-1:0]                   o_rad
);

    localparam int DW = rmq_pkg::D_W;
    localparam logic signed [RAD_W-1:0] ONE = {{(RAD_W-1){1'b0}}, 1'b1} << FRAC_BITS;

    logic signed [RAD_W-1:0] e00, e11, e22, trace, rad_sel;
    logic signed [DW-1:0]    d_21m12, d_02m20, d_10m01, d_01p10, d_02p20, d_12p21;
    rmq_pkg::t_side          n_side;
    logic [RAD_W-1:0]        n_rad;
    rmq_pkg::t_side          r_side;
    logic [RAD_W-1:0]        r_rad;
    logic                    r_valid;

    // Diagonal, trace and the six off-diagonal combinations.
    always_comb begin
        e00     = RAD_W'(i_r00);
        e11     = RAD_W'(i_r11);
        e22     = RAD_W'(i_r22);
        trace   = e00 + e11 + e22;
        d_21m12 = DW'(i_r21) - DW'(i_r12);
        d_02m20 = DW'(i_r02) - DW'(i_r20);
        d_10m01 = DW'(i_r10) - DW'(i_r01);
        d_01p10 = DW'(i_r01) + DW'(i_r10);
        d_02p20 = DW'(i_r02) + DW'(i_r20);
        d_12p21 = DW'(i_r12) + DW'(i_r21);
    end

    // Pick the square-root component; ties fall through to the later choice.
    always_comb begin
        if (trace > 0) begin
            n_side.sel = rmq_pkg::SEL_TRACE;
            rad_sel    = trace + ONE;
            n_side.d   = {d_10m01, d_02m20, d_21m12};
        end else if (i_r00 > i_r11 && i_r00 > i_r22) begin
            n_side.sel = rmq_pkg::SEL_X;
            rad_sel    = ONE + e00 - e11 - e22;
            n_side.d   = {d_02p20, d_01p10, d_21m12};
        end else if (i_r11 > i_r22) begin
            n_side.sel = rmq_pkg::SEL_Y;
            rad_sel    = ONE + e11 - e00 - e22;
            n_side.d   = {d_12p21, d_01p10, d_02m20};
        end else begin
            n_side.sel = rmq_pkg::SEL_Z;
            rad_sel    = ONE + e22 - e00 - e11;
            n_side.d   = {d_12p21, d_02p20, d_10m01};
        end
        // A non-positive radicand is taken as zero.
        n_rad = (rad_sel > 0) ? rad_sel : '0;
    end

    // Stage register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side <= n_side;
            r_rad  <= n_rad;
        end
    end

    assign o_valid = r_valid;
    assign o_side  = r_side;
    assign o_rad   = r_rad;

endmodule

FILE: design/rmq_sqrt.sv
// Pipelined integer square root, one root bit per stage.
`timescale 1ns / 1ps

module rmq_sqrt #(
    parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF,
    parameter int RAD_W     = 21,
    parameter int ROOT_W    = 19
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  rmq_pkg::t_side        i_side,
    input  logic [RAD_W-1:0]      i_rad,
    output logic                  o_valid,
    output rmq_pkg::t_side        o_side,
    output logic [ROOT_W-1:0]     o_root
);

    localparam int OP_W  = 2 * ROOT_W;
    localparam int REM_W = ROOT_W + 2;

    // Stage inputs (w_) and stage registers (r_), one entry per root bit.
    logic [OP_W-1:0]   w_op   [ROOT_W];
    logic [ROOT_W-1:0] w_rem  [ROOT_W];
    logic [ROOT_W-1:0] w_root [ROOT_W];
    rmq_pkg::t_side    w_side [ROOT_W];
    logic [ROOT_W-1:0] w_vld;

    logic [OP_W-1:0]   r_op   [ROOT_W];
    logic [ROOT_W-1:0] r_rem  [ROOT_W];
    logic [ROOT_W-1:0] r_root [ROOT_W];
    rmq_pkg::t_side    r_side [ROOT_W];
    logic [ROOT_W-1:0] r_vld;

    // The operand is the radicand scaled up by the fraction bits.
    assign w_op[0]   = OP_W'(i_rad) << FRAC_BITS;
    assign w_rem[0]  = '0;
    assign w_root[0] = '0;
    assign w_side[0] = i_side;
    assign w_vld[0]  = i_valid;

    for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
        logic [REM_W-1:0]  rem2, trial, diff;
        logic              ge;
        logic [ROOT_W-1:0] n_rem, n_root;

        if (k > 0) begin : g_link
            assign w_op[k]   = r_op[k-1];
            assign w_rem[k]  = r_rem[k-1];
            assign w_root[k] = r_root[k-1];
            assign w_side[k] = r_side[k-1];
            assign w_vld[k]  = r_vld[k-1];
        end

        // Bring in two operand bits and try the next root bit.
        always_comb begin
            rem2   = {w_rem[k], w_op[k][OP_W-1 -: 2]};
            trial  = {w_root[k], 2'b01};
            ge     = (rem2 >= trial);
            diff   = rem2 - trial;
            n_rem  = ge ? diff[ROOT_W-1:0] : rem2[ROOT_W-1:0];
            n_root = {w_root[k][ROOT_W-2:0], ge};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= w_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_op[k]   <= w_op[k] << 2;
                r_rem[k]  <= n_rem;
                r_root[k] <= n_root;
                r_side[k] <= w_side[k];
            end
        end
    end

    assign o_valid = r_vld[ROOT_W-1];
    assign o_side  = r_side[ROOT_W-1];
    assign o_root  = r_root[ROOT_W-1];

endmodule

FILE: design/rmq_div.sv
// Pipelined three-lane restoring divider, one quotient bit per stage after the first.
`timescale 1ns / 1ps

module rmq_div #(
    parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF,
    parameter int ROOT_W    = 19
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic                                i_valid,
    input  rmq_pkg::t_side                      i_side,
    input  logic [ROOT_W-1:0]                   i_root,
    output logic                                o_valid,
    output rmq_pkg::t_sel                       o_sel,
    output logic [ROOT_W-1:0]                   o_root,
    output logic [2:0][rmq_pkg::QUO_W-1:0]      o_quo,
    output logic [2:0]                          o_ovf,
    output logic [2:0]                          o_neg
);

    localparam int QW    = rmq_pkg::QUO_W;
    localparam int DW    = rmq_pkg::D_W;
    // Dividend magnitude times 2^(FRAC_BITS-1); the divisor is the root itself.
    // The magnitude keeps all DW bits, as the most negative sum has no sign bit to spare.
    localparam int NUM_W = FRAC_BITS + DW - 1;
    localparam int HI_W  = NUM_W - QW;
    localparam int CMP_W = (HI_W > ROOT_W) ? HI_W : ROOT_W;
    localparam int NST   = QW + 1;

    logic [2:0][ROOT_W-1:0] w_rem  [NST];
    logic [2:0][QW-1:0]     w_low  [NST];
    logic [2:0][QW-1:0]     w_quo  [NST];
    logic [2:0]             w_ovf  [NST];
    logic [2:0]             w_neg  [NST];
    logic [ROOT_W-1:0]      w_root [NST];
    rmq_pkg::t_sel          w_sel  [NST];
    logic [NST-1:0]         w_vld;

    logic [2:0][ROOT_W-1:0] r_rem  [NST];
    logic [2:0][QW-1:0]     r_low  [NST];
    logic [2:0][QW-1:0]     r_quo  [NST];
    logic [2:0]             r_ovf  [NST];
    logic [2:0]             r_neg  [NST];
    logic [ROOT_W-1:0]      r_root [NST];
    rmq_pkg::t_sel          r_sel  [NST];
    logic [NST-1:0]         r_vld;

    logic [2:0][ROOT_W-1:0] n_rem  [NST];
    logic [2:0][QW-1:0]     n_low  [NST];
    logic [2:0][QW-1:0]     n_quo  [NST];
    logic [2:0]             n_ovf  [NST];

    // First stage: magnitudes, sign and the overflow check on the top bits.
    always_comb begin
        logic signed [DW-1:0] d;
        logic [DW-1:0]        mag;
        logic [NUM_W-1:0]     num;
        logic [CMP_W-1:0]     hi;
        for (int l = 0; l < 3; l++) begin
            d           = $signed(i_side.d[l]);
            mag         = (d < 0) ? DW'(-d) : DW'(d);
            num         = NUM_W'(mag) << (FRAC_BITS - 1);
            hi          = CMP_W'(num[NUM_W-1:QW]);
            w_neg[0][l] = (d < 0);
            n_ovf[0][l] = (hi >= CMP_W'(i_root));
            n_rem[0][l] = hi[ROOT_W-1:0];
            n_low[0][l] = num[QW-1:0];
            n_quo[0][l] = '0;
        end
    end

    assign w_root[0] = i_root;
    assign w_sel[0]  = i_side.sel;
    assign w_vld[0]  = i_valid;
    assign w_rem[0]  = '0;
    assign w_low[0]  = '0;
    assign w_quo[0]  = '0;
    assign w_ovf[0]  = '0;

    for (genvar j = 1; j < NST; j++) begin : g_step
        assign w_rem[j]  = r_rem[j-1];
        assign w_low[j]  = r_low[j-1];
        assign w_quo[j]  = r_quo[j-1];
        assign w_ovf[j]  = r_ovf[j-1];
        assign w_neg[j]  = r_neg[j-1];
        assign w_root[j] = r_root[j-1];
        assign w_sel[j]  = r_sel[j-1];
        assign w_vld[j]  = r_vld[j-1];

        // Shift in one dividend bit per lane and subtract the divisor if it fits.
        always_comb begin
            logic [ROOT_W:0] rem2, diff;
            logic            ge;
            for (int l = 0; l < 3; l++) begin
                rem2        = {w_rem[j][l], w_low[j][l][QW-1]};
                ge          = (rem2 >= {1'b0, w_root[j]});
                diff        = rem2 - {1'b0, w_root[j]};
                n_rem[j][l] = ge ? diff[ROOT_W-1:0] : rem2[ROOT_W-1:0];
                n_low[j][l] = {w_low[j][l][QW-2:0], 1'b0};
                n_quo[j][l] = {w_quo[j][l][QW-2:0], ge};
                n_ovf[j][l] = w_ovf[j][l];
            end
        end
    end

    for (genvar j = 0; j < NST; j++) begin : g_reg
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[j] <= 1'b0;
            end else if (i_en) begin
                r_vld[j] <= w_vld[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j]  <= n_rem[j];
                r_low[j]  <= n_low[j];
                r_quo[j]  <= n_quo[j];
                r_ovf[j]  <= n_ovf[j];
                r_neg[j]  <= w_neg[j];
                r_root[j] <= w_root[j];
                r_sel[j]  <= w_sel[j];
            end
        end
    end

    assign o_valid = r_vld[NST-1];
    assign o_sel   = r_sel[NST-1];
    assign o_root  = r_root[NST-1];
    assign o_quo   = r_quo[NST-1];
    assign o_ovf   = r_ovf[NST-1];
    assign o_neg   = r_neg[NST-1];

endmodule

FILE: design/rmq_checker.sv
// Port checker for the rotation matrix to quaternion block, with its bind.
`timescale 1ns / 1ps
`include "rotation_matrix_to_quaternion_macros.svh"

module rmq_checker #(
    parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               o_ready,
    input  logic                               o_valid,
    input  logic                               i_ready,
    input  logic signed [rmq_pkg::FIELD_W-1:0] o_qx,
    input  logic signed [rmq_pkg::FIELD_W-1:0] o_qy,
    input  logic signed [rmq_pkg::FIELD_W-1:0] o_qz,
    input  logic signed [rmq_pkg::FIELD_W-1:0] o_qw
);

    localparam int LIM = (FRAC_BITS > rmq_pkg::FIELD_W - 2) ?
                         rmq_pkg::FIELD_MAX : (1 << FRAC_BITS);

    logic in_range;

    // All four components inside the clamp range.
    assign in_range = (o_qx <= LIM) && (o_qx >= -LIM) &&
                      (o_qy <= LIM) && (o_qy >= -LIM) &&
                      (o_qz <= LIM) && (o_qz >= -LIM) &&
                      (o_qw <= LIM) && (o_qw >= -LIM);

    // A waiting result stays offered until it is taken.
    `RMQ_ASSERT(a_out_hold, o_valid && !i_ready |=> o_valid, "result dropped while stalled")

    // A stalled output stops the whole pipeline, so no new transfer is taken.
    `RMQ_ASSERT(a_stall_blocks, o_valid && !i_ready |-> !o_ready, "input taken during stall")

    // Reset empties the output register.
    `RMQ_ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> !o_valid, "valid result after reset")

    // Every component lies within the clamp range.
    `RMQ_ASSERT(a_range, o_valid |-> in_range, "component out of range")

endmodule

bind rotation_matrix_to_quaternion rmq_checker #(.FRAC_BITS(FRAC_BITS)) u_rmq_checker (.*);
